>>> rtl/hit_cluster_demarcation_top_macros.svh
// Assertion macros shared by the cluster demarcation RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef HIT_CLUSTER_DEMARCATION_TOP_MACROS_SVH
`define HIT_CLUSTER_DEMARCATION_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HCD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled during reset.
`define HCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

>>> rtl/hcd_pkg.sv
// Package for the cluster demarcation block: types, register indexes and reset values.
// Has no dependencies; imported by every RTL module of the block.
package hcd_pkg;

    localparam int CFG_W    = 16;
    localparam int REGION_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLUSTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN    = 2'd2;

    localparam logic [CFG_W-1:0] MAX_GAP_RESET     = 16'd10;
    localparam logic [CFG_W-1:0] MIN_CLUSTER_RESET = 16'd15;
    localparam logic [CFG_W-1:0] MIN_SPAN_RESET    = 16'd15;

    typedef enum logic [1:0] {
        STATUS_FOUND      = 2'd0,
        STATUS_NO_HITS    = 2'd1,
        STATUS_NO_CLUSTER = 2'd2,
        STATUS_SHORT_SPAN = 2'd3
    } status_t;

    typedef struct packed {
        logic hit;
        logic last;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] max_gap;
        logic [CFG_W-1:0] min_cluster_size;
        logic [CFG_W-1:0] min_span;
    } cfg_t;

    typedef struct packed {
        logic any_hit;
        logic have;
    } summary_t;

endpackage

>>> rtl/hcd_in_stage.sv
// Input register of the cluster demarcation block: holds one match flag transfer.
// Depends on hcd_pkg.
module hcd_in_stage
    import hcd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  logic  s_hit,
    input  logic  s_last,
    output logic  item_valid,
    output item_t item,
    input  logic  item_ready
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || item_ready;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.hit  <= s_hit;
            item_reg.last <= s_last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/hcd_cluster.sv
// Cluster tracker: numbers positions, splits hits into clusters and latches a summary on last.
// Depends on hcd_pkg and the shared assertion macros.
`include "hit_cluster_demarcation_top_macros.svh"

module hcd_cluster
    import hcd_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_ready,
    output logic                 sum_valid,
    output summary_t             sum,
    output logic [POS_WIDTH-1:0] sum_begin,
    output logic [POS_WIDTH-1:0] sum_final,
    input  logic                 sum_ready
);

    localparam int CMP_W = (POS_WIDTH > CFG_W) ? POS_WIDTH : CFG_W;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    logic [POS_WIDTH-1:0] pos_count_reg, pos_count_next;
    logic                 any_hit_reg, any_hit_next;
    logic [POS_WIDTH-1:0] prev_hit_reg, prev_hit_next;
    logic [POS_WIDTH-1:0] cluster_size_reg, cluster_size_next;
    logic [POS_WIDTH-1:0] cluster_first_reg, cluster_first_next;
    logic                 found_start_reg, found_start_next;
    logic [POS_WIDTH-1:0] start_value_reg, start_value_next;
    logic [POS_WIDTH-1:0] end_value_reg, end_value_next;

    logic                 sum_valid_reg;
    summary_t             sum_reg, sum_next;
    logic [POS_WIDTH-1:0] sum_begin_reg, sum_begin_next;
    logic [POS_WIDTH-1:0] sum_final_reg, sum_final_next;

    logic                 sum_free;
    logic                 advance;
    logic [POS_WIDTH-1:0] gap;
    logic                 gap_big;
    logic                 closed_ok;
    logic                 final_ok;
    logic [POS_WIDTH-1:0] size_base;

    assign sum_free   = !sum_valid_reg || sum_ready;
    assign item_ready = !item.last || sum_free;
    assign advance    = item_valid && item_ready;

    assign gap       = pos_count_reg - prev_hit_reg;
    assign gap_big   = CMP_W'(gap) > CMP_W'(cfg.max_gap);
    assign closed_ok = (cluster_size_reg > POS_WIDTH'(1))
                    && (CMP_W'(cluster_size_reg) > CMP_W'(cfg.min_cluster_size));

    always_comb begin
        any_hit_next       = any_hit_reg;
        prev_hit_next      = prev_hit_reg;
        cluster_first_next = cluster_first_reg;
        found_start_next   = found_start_reg;
        start_value_next   = start_value_reg;
        end_value_next     = end_value_reg;
        size_base          = cluster_size_reg;
        cluster_size_next  = cluster_size_reg;
        if (item.hit) begin
            if (!any_hit_reg) begin
                cluster_first_next = pos_count_reg;
                size_base          = '0;
            end else if (gap_big) begin
                if (closed_ok) begin
                    if (!found_start_reg) begin
                        start_value_next = cluster_first_reg;
                        found_start_next = 1'b1;
                    end
                    end_value_next = prev_hit_reg;
                end
                size_base          = '0;
                cluster_first_next = pos_count_reg;
            end
            cluster_size_next = (size_base == POS_MAX) ? size_base : size_base + 1'b1;
            prev_hit_next     = pos_count_reg;
            any_hit_next      = 1'b1;
        end
        pos_count_next = (pos_count_reg == POS_MAX) ? pos_count_reg : pos_count_reg + 1'b1;
    end

    assign final_ok = CMP_W'(cluster_size_next) > CMP_W'(cfg.min_cluster_size);

    always_comb begin
        sum_next.any_hit = any_hit_next;
        sum_next.have    = any_hit_next && (final_ok || found_start_next);
        sum_begin_next   = '0;
        sum_final_next   = '0;
        if (sum_next.have) begin
            if (final_ok) begin
                sum_begin_next = found_start_next ? start_value_next : cluster_first_next;
                sum_final_next = prev_hit_next;
            end else begin
                sum_begin_next = start_value_next;
                sum_final_next = end_value_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_count_reg     <= '0;
            any_hit_reg       <= 1'b0;
            prev_hit_reg      <= '0;
            cluster_size_reg  <= '0;
            cluster_first_reg <= '0;
            found_start_reg   <= 1'b0;
            start_value_reg   <= '0;
            end_value_reg     <= '0;
        end else if (advance) begin
            if (item.last) begin
                pos_count_reg     <= '0;
                any_hit_reg       <= 1'b0;
                prev_hit_reg      <= '0;
                cluster_size_reg  <= '0;
                cluster_first_reg <= '0;
                found_start_reg   <= 1'b0;
                start_value_reg   <= '0;
                end_value_reg     <= '0;
            end else begin
                pos_count_reg     <= pos_count_next;
                any_hit_reg       <= any_hit_next;
                prev_hit_reg      <= prev_hit_next;
                cluster_size_reg  <= cluster_size_next;
                cluster_first_reg <= cluster_first_next;
                found_start_reg   <= found_start_next;
                start_value_reg   <= start_value_next;
                end_value_reg     <= end_value_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (advance && item.last) begin
            sum_valid_reg <= 1'b1;
        end else if (sum_ready) begin
            sum_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item.last) begin
            sum_reg       <= sum_next;
            sum_begin_reg <= sum_begin_next;
            sum_final_reg <= sum_final_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;
    assign sum_begin = sum_begin_reg;
    assign sum_final = sum_final_reg;

    `HCD_ASSERT_NEXT(a_pos_step, aclk, aresetn, advance && !item.last && (pos_count_reg != POS_MAX), pos_count_reg == $past(pos_count_reg) + 1'b1)
    `HCD_ASSERT_IMPLY(a_idle_clear, aclk, aresetn, !any_hit_reg, (cluster_size_reg == '0) && !found_start_reg)
    `HCD_ASSERT_IMPLY(a_found_order, aclk, aresetn, found_start_reg, start_value_reg <= end_value_reg)

endmodule

>>> rtl/hcd_result.sv
// Result register: turns a sequence summary into status and region bounds.
// Depends on hcd_pkg and the shared assertion macros.
`include "hit_cluster_demarcation_top_macros.svh"

module hcd_result
    import hcd_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CFG_W-1:0]     min_span,
    input  logic                 sum_valid,
    input  summary_t             sum,
    input  logic [POS_WIDTH-1:0] sum_begin,
    input  logic [POS_WIDTH-1:0] sum_final,
    output logic                 sum_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [REGION_W-1:0]  m_region_begin,
    output logic [REGION_W-1:0]  m_region_final
);

    localparam int CMP_W = (POS_WIDTH > CFG_W) ? POS_WIDTH : CFG_W;

    logic                m_valid_reg;
    status_t             status_reg, status_next;
    logic [REGION_W-1:0] begin_reg, begin_next;
    logic [REGION_W-1:0] final_reg, final_next;

    logic                 out_free;
    logic [POS_WIDTH-1:0] span;
    logic                 span_long;
    logic [CMP_W-1:0]     begin_ext;
    logic [CMP_W-1:0]     final_ext;

    assign out_free  = !m_valid_reg || m_ready;
    assign sum_ready = out_free;

    assign span      = sum_final - sum_begin;
    assign span_long = CMP_W'(span) > CMP_W'(min_span);
    assign begin_ext = CMP_W'(sum_begin);
    assign final_ext = CMP_W'(sum_final);

    always_comb begin
        begin_next = '0;
        final_next = '0;
        priority if (!sum.any_hit) begin
            status_next = STATUS_NO_HITS;
        end else if (!sum.have) begin
            status_next = STATUS_NO_CLUSTER;
        end else begin
            status_next = span_long ? STATUS_FOUND : STATUS_SHORT_SPAN;
            begin_next  = begin_ext[REGION_W-1:0];
            final_next  = final_ext[REGION_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_valid && out_free) begin
            status_reg <= status_next;
            begin_reg  <= begin_next;
            final_reg  <= final_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_region_begin = begin_reg;
    assign m_region_final = final_reg;

    `HCD_ASSERT_IMPLY(a_empty_region, aclk, aresetn, m_valid_reg && ((status_reg == STATUS_NO_HITS) || (status_reg == STATUS_NO_CLUSTER)), (begin_reg == '0) && (final_reg == '0))
    `HCD_ASSERT_IMPLY(a_region_order, aclk, aresetn, m_valid_reg && (status_reg == STATUS_FOUND), begin_reg != final_reg)

endmodule

>>> rtl/hit_cluster_demarcation_top.sv
// A result reaches m_valid via the input register, the tracker's summary register and the result register.
// Throughput: one match flag per cycle; every stage advances each cycle that m_ready allows.
// The figure is set by the cluster tracker, whose state updates once per position.
// Reset (aresetn low, synchronous): sequence state and valids clear at once, and the
// registers return to max_gap 10, min_cluster_size 15, min_span 15.
module hit_cluster_demarcation_top
    import hcd_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_hit,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [REGION_W-1:0]  m_region_begin,
    output logic [REGION_W-1:0]  m_region_final,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t cfg_reg, cfg_next;

    logic                 item_valid;
    item_t                item;
    logic                 item_ready;
    logic                 sum_valid;
    summary_t             sum;
    logic [POS_WIDTH-1:0] sum_begin;
    logic [POS_WIDTH-1:0] sum_final;
    logic                 sum_ready;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MAX_GAP:     cfg_next.max_gap          = cfg_data;
                CFG_MIN_CLUSTER: cfg_next.min_cluster_size = cfg_data;
                CFG_MIN_SPAN:    cfg_next.min_span         = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_gap          <= MAX_GAP_RESET;
            cfg_reg.min_cluster_size <= MIN_CLUSTER_RESET;
            cfg_reg.min_span         <= MIN_SPAN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hcd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_hit      (s_hit),
        .s_last     (s_last),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    hcd_cluster #(
        .POS_WIDTH (POS_WIDTH)
    ) u_cluster (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .sum_valid  (sum_valid),
        .sum        (sum),
        .sum_begin  (sum_begin),
        .sum_final  (sum_final),
        .sum_ready  (sum_ready)
    );

    hcd_result #(
        .POS_WIDTH (POS_WIDTH)
    ) u_result (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .min_span       (cfg_reg.min_span),
        .sum_valid      (sum_valid),
        .sum            (sum),
        .sum_begin      (sum_begin),
        .sum_final      (sum_final),
        .sum_ready      (sum_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_region_begin (m_region_begin),
        .m_region_final (m_region_final)
    );

endmodule
